@@ rtl/bvd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvd_pkg: shared types for the bounded vector deque unit
// Operation and status codes, controller states and the command bundle that
// passes from the controller to the datapath.
// ----------------------------------------------------------------------------
package bvd_pkg;

  typedef enum logic [1:0] {
    OP_APPEND     = 2'd0,
    OP_DROP_FIRST = 2'd1,
    OP_DROP_LAST  = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;     // Execute the request on the input ports this cycle.
    logic present;  // Drive the registered result onto the output ports.
  } cmd_t;

  localparam int WORD_W  = 32;
  localparam int POS_W   = 8;
  localparam int COUNT_W = 8;

endpackage

@@ rtl/bvd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bvd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/bvd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvd_ctrl: request sequencer
// Accepts one request, then presents its result in the next cycle.
// ----------------------------------------------------------------------------
module bvd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output bvd_pkg::cmd_t cmd
);
  import bvd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.exec    = 1'b0;
    cmd.present = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.exec  = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        cmd.present = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r == S_RESP);

endmodule

@@ rtl/bvd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvd_datapath: circular buffer pointers, word store and result registers
// Executes one request on command and holds its result for presentation.
// ----------------------------------------------------------------------------
module bvd_datapath #(
  parameter int CAPACITY = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bvd_pkg::cmd_t                       cmd,
  input  logic [1:0]                          in_op,
  input  logic signed [bvd_pkg::WORD_W-1:0]   in_value,
  input  logic [bvd_pkg::POS_W-1:0]           in_position,
  output logic                                out_valid,
  output logic signed [bvd_pkg::WORD_W-1:0]   out_read_word,
  output logic [bvd_pkg::COUNT_W-1:0]         out_element_count,
  output logic [1:0]                          out_status
);
  import bvd_pkg::*;

  localparam int PW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [PW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  status_t           status_r, status_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  logic              ram_we, ram_re;
  logic [PW-1:0]     tail_slot, read_slot, head_inc;
  logic [WORD_W-1:0] ram_rdata;
  logic [CMPW-1:0]   pos_ext, cnt_ext;
  logic              is_full, is_empty, in_range;
  op_t               op;

  // Head plus an offset below the capacity, wrapped into the buffer.
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                             input logic [PW-1:0] b);
    logic [PW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (PW+1)'(CAPACITY)) begin
      sum = sum - (PW+1)'(CAPACITY);
    end
    return sum[PW-1:0];
  endfunction

  assign op        = op_t'(in_op);
  assign is_full   = (cnt_r == CW'(CAPACITY));
  assign is_empty  = (cnt_r == '0);
  assign pos_ext   = CMPW'(in_position);
  assign cnt_ext   = CMPW'(cnt_r);
  assign in_range  = (pos_ext < cnt_ext);
  assign tail_slot = wrap_add(head_r, cnt_r[PW-1:0]);
  assign read_slot = wrap_add(head_r, pos_ext[PW-1:0]);
  assign head_inc  = wrap_add(head_r, PW'(1));

  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    rd_ok_nxt  = rd_ok_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    if (cmd.exec) begin
      status_nxt = ST_OK;
      rd_ok_nxt  = 1'b0;
      unique case (op)
        OP_APPEND: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        OP_DROP_FIRST: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            head_nxt = head_inc;
            cnt_nxt  = cnt_r - CW'(1);
          end
        end
        OP_DROP_LAST: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
        OP_READ: begin
          if (!in_range) begin
            status_nxt = ST_RANGE;
          end else begin
            ram_re    = 1'b1;
            rd_ok_nxt = 1'b1;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rd_ok_r  <= rd_ok_nxt;
  end

  bvd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_slot),
    .wdata (in_value),
    .re    (ram_re),
    .raddr (read_slot),
    .rdata (ram_rdata)
  );

  assign out_valid         = cmd.present;
  assign out_read_word     = rd_ok_r ? $signed(ram_rdata) : '0;
  assign out_element_count = cnt_ext[COUNT_W-1:0];
  assign out_status        = status_r;

endmodule

@@ rtl/bounded_vector_deque_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_vector_deque_unit: bounded deque of signed words with indexed read
// A circular buffer of up to CAPACITY 32-bit words. Each request appends at
// the tail, drops the first or last element, or reads by position from the
// front, and returns one result with the read word, the count and a status.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+--------------------------------------------
//  request  | start, busy        | in_op, in_value, in_position
//  result   | out_valid (strobe) | out_read_word, out_element_count, out_status
//
// An item is accepted at a clock edge where start is high and busy is low.
// Every item has an accept cycle, in which the pointers update and the word
// store is written or read, followed by a result cycle, in which the
// registered read port of the store delivers the word. busy is high during
// the result cycle, so no new item is accepted until that result is shown.
// Reset is synchronous and active low; it empties the deque at once, and the
// word store itself needs no clearing. The receiver cannot stall: each result
// is shown for exactly one cycle, marked by out_valid.
//
module bounded_vector_deque_unit #(
  parameter int CAPACITY = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_op,
  input  logic signed [bvd_pkg::WORD_W-1:0] in_value,
  input  logic [bvd_pkg::POS_W-1:0]         in_position,
  output logic                              out_valid,
  output logic signed [bvd_pkg::WORD_W-1:0] out_read_word,
  output logic [bvd_pkg::COUNT_W-1:0]       out_element_count,
  output logic [1:0]                        out_status
);
  import bvd_pkg::*;

  cmd_t cmd;

  // The controller sequences accept and result cycles.
  bvd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds the pointers, the word store and the result registers.
  bvd_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_op             (in_op),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_read_word     (out_read_word),
    .out_element_count (out_element_count),
    .out_status        (out_status)
  );

  // Every result follows an accepted item in the cycle before it.
  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result strobe without a preceding accepted item");

  // An accepted item always produces its result in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted item produced no result");

  // A failed request never returns a word.
  a_fail_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_read_word == '0))
    else $error("nonzero read word on a failed request");

  // Results are single-cycle strobes, never back to back.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

endmodule

@@ sim/bounded_vector_deque_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_vector_deque_unit_test: self-checking bench for the deque unit
// Drives append, remove-first, remove-last and indexed-read items through the
// start/busy handshake, predicts every result with a shadow copy of the deque
// and compares each out_valid strobe against the oldest prediction. A short
// directed list covers the edge cases; random segments then fill the deque to
// capacity, drain it to empty and wrap the head pointer, with the sender idle
// at different rates from segment to segment.
// ----------------------------------------------------------------------------
module bounded_vector_deque_unit_test;
  import bvd_pkg::*;

  localparam int DEPTH        = 128;
  localparam int RANDOM_ITEMS = 2000;

  // One request waiting in the driver queue, along with how the driver should
  // present it: the chance of idling before it and whether it must wait for
  // every earlier result first.
  typedef struct {
    op_t                       op;
    logic signed [WORD_W-1:0]  value;
    logic [POS_W-1:0]          position;
    int                        idle_pct;
    bit                        wait_drain;
  } deque_request_t;

  typedef struct {
    logic signed [WORD_W-1:0]  read_word;
    logic [COUNT_W-1:0]        element_count;
    status_t                   status;
  } deque_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                in_op = 2'd0;
  logic signed [WORD_W-1:0]  in_value = '0;
  logic [POS_W-1:0]          in_position = '0;
  logic                      out_valid;
  logic signed [WORD_W-1:0]  out_read_word;
  logic [COUNT_W-1:0]        out_element_count;
  logic [1:0]                out_status;

  deque_request_t request_queue[$];
  deque_result_t  expected_results[$];

  // Both counters are updated with nonblocking assignments, so any process
  // that reads them at a clock edge sees the totals from before that edge.
  int sent_count = 0;
  int results_seen = 0;
  int total_items = 0;
  int error_count = 0;

  // Shadow of the deque contents, kept by the predictor.
  logic signed [WORD_W-1:0] shadow_words[DEPTH];
  int shadow_head = 0;
  int shadow_fill = 0;

  // Tallies for the end-of-run summary.
  int status_tally[4] = '{0, 0, 0, 0};
  int full_hits = 0;
  int head_wraps = 0;

  // Stimulus builder state: the fill level the deque will have once every
  // queued item has run, plus the idle rate and drain flag for the next item.
  int gen_fill = 0;
  int gen_idle_pct = 0;
  bit gen_wait_drain = 1'b0;

  bounded_vector_deque_unit #(
    .CAPACITY(DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_read_word     (out_read_word),
    .out_element_count (out_element_count),
    .out_status        (out_status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // Applies one request to the shadow deque and returns the result the unit
  // must produce for it. A failed request leaves the shadow untouched.
  function automatic deque_result_t deque_predict(input op_t op,
                                                  input logic signed [WORD_W-1:0] value,
                                                  input logic [POS_W-1:0] position);
    deque_result_t r;
    r.read_word = '0;
    r.status = ST_OK;
    case (op)
      OP_APPEND: begin
        if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[(shadow_head + shadow_fill) % DEPTH] = value;
          shadow_fill++;
          if (shadow_fill == DEPTH) full_hits++;
        end
      end
      OP_DROP_FIRST: begin
        // Removing at the front only moves the head; it wraps at the top.
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_fill--;
          if (shadow_head == 0) head_wraps++;
        end
      end
      OP_DROP_LAST: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else shadow_fill--;
      end
      default: begin
        // Any position at or past the count is out of range, including every
        // read of an empty deque.
        if (int'(position) >= shadow_fill) r.status = ST_RANGE;
        else r.read_word = shadow_words[(shadow_head + int'(position)) % DEPTH];
      end
    endcase
    r.element_count = COUNT_W'(shadow_fill);
    status_tally[r.status]++;
    return r;
  endfunction

  // Queues one request and tracks the fill level it leaves behind, so that
  // the random part can aim reads at valid positions.
  task automatic queue_request(input op_t op, input logic [WORD_W-1:0] value,
                               input logic [POS_W-1:0] position);
    deque_request_t q;
    q.op = op;
    q.value = value;
    q.position = position;
    q.idle_pct = gen_idle_pct;
    q.wait_drain = gen_wait_drain;
    gen_wait_drain = 1'b0;
    request_queue.push_back(q);
    case (op)
      OP_APPEND:     if (gen_fill < DEPTH) gen_fill++;
      OP_DROP_FIRST,
      OP_DROP_LAST:  if (gen_fill > 0) gen_fill--;
      default: ;
    endcase
  endtask

  task automatic build_stimulus();
    int phase_pct[4] = '{0, 47, 0, 34};
    int segment = 0;
    int seg_len;
    int mode;
    int pick;
    op_t op;
    logic [WORD_W-1:0] value;
    logic [POS_W-1:0] position;

    // Directed part: empty-deque failures at both ends of the position range,
    // extreme words, reads at the first, last and first invalid position, and
    // removals from both ends down to empty again.
    queue_request(OP_READ, '0, 8'd0);
    queue_request(OP_READ, '0, 8'd255);
    queue_request(OP_DROP_FIRST, '0, '0);
    queue_request(OP_DROP_LAST, '0, '0);
    queue_request(OP_APPEND, 32'h7fff_ffff, 8'hff);
    queue_request(OP_APPEND, 32'h8000_0000, '0);
    queue_request(OP_APPEND, 32'h0000_0000, '0);
    queue_request(OP_APPEND, 32'hffff_ffff, '0);
    queue_request(OP_APPEND, 32'haaaa_5555, '0);
    queue_request(OP_READ, 32'hffff_ffff, 8'd0);
    queue_request(OP_READ, '0, 8'd1);
    queue_request(OP_READ, '0, 8'd4);
    queue_request(OP_READ, '0, 8'd5);
    queue_request(OP_READ, '0, 8'd255);
    queue_request(OP_DROP_FIRST, '0, '0);
    queue_request(OP_READ, '0, 8'd0);
    queue_request(OP_DROP_LAST, '0, '0);
    queue_request(OP_READ, '0, 8'd2);
    queue_request(OP_READ, '0, 8'd3);
    queue_request(OP_DROP_LAST, '0, '0);
    queue_request(OP_DROP_FIRST, '0, '0);
    queue_request(OP_DROP_LAST, '0, '0);
    queue_request(OP_DROP_LAST, '0, '0);
    queue_request(OP_DROP_FIRST, '0, '0);
    queue_request(OP_APPEND, 32'h1234_5678, '0);

    // Random part in segments. A fill segment is long enough to push the
    // deque past capacity, a drain segment to empty it, and the mixed one
    // wanders in between. Each segment starts by waiting for all earlier
    // results and then runs at its own sender idle rate.
    while (request_queue.size() < RANDOM_ITEMS + 25) begin
      mode = segment % 3;
      seg_len = $urandom_range(260, 150);
      gen_idle_pct = phase_pct[segment % 4];
      gen_wait_drain = 1'b1;
      repeat (seg_len) begin
        pick = $urandom_range(99);
        case (mode)
          0: op = (pick < 80) ? OP_APPEND : (pick < 92) ? OP_READ :
                  (pick < 96) ? OP_DROP_FIRST : OP_DROP_LAST;
          1: op = (pick < 40) ? OP_DROP_FIRST : (pick < 75) ? OP_DROP_LAST :
                  (pick < 90) ? OP_READ : OP_APPEND;
          default: op = op_t'($urandom_range(3));
        endcase
        pick = $urandom_range(99);
        if (pick < 8) value = 32'h8000_0000;
        else if (pick < 16) value = 32'h7fff_ffff;
        else value = $urandom;
        // Most reads hit a stored element; the rest take any position.
        if (gen_fill > 0 && $urandom_range(99) < 75)
          position = POS_W'($urandom_range(gen_fill - 1));
        else
          position = POS_W'($urandom_range(255));
        queue_request(op, value, position);
      end
      segment++;
    end
    total_items = request_queue.size();
  endtask

  // Driver. An item is presented when the previous one has been taken, its
  // drain wait (if any) is over and the random idle draw lets it go; while
  // busy holds it off, start and the fields stay as they are. Each signal gets
  // at most one nonblocking assignment per edge.
  always @(posedge clk) begin : drive
    logic fire;
    int sent_now;
    bit go;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      fire = start && !busy;
      sent_now = sent_count + (fire ? 1 : 0);
      if (fire) begin
        void'(request_queue.pop_front());
        sent_count <= sent_now;
      end
      if (!(start && !fire)) begin
        go = request_queue.size() > 0;
        if (go && request_queue[0].wait_drain && sent_now != results_seen) go = 1'b0;
        if (go && $urandom_range(99) < request_queue[0].idle_pct) go = 1'b0;
        if (go) begin
          start <= 1'b1;
          in_op <= request_queue[0].op;
          in_value <= request_queue[0].value;
          in_position <= request_queue[0].position;
        end else begin
          // Idle cycles carry random junk on the fields to show it is ignored.
          start <= 1'b0;
          in_op <= 2'($urandom_range(3));
          in_value <= $urandom;
          in_position <= POS_W'($urandom_range(255));
        end
      end
    end
  end

  // Monitor. The prediction for an item accepted at this edge goes in before
  // the result check, so the order of expectations holds whatever the
  // latency of the unit turns out to be.
  always @(posedge clk) begin : check
    deque_result_t want;
    if (rst_n) begin
      if (start && !busy)
        expected_results.push_back(deque_predict(op_t'(in_op), in_value, in_position));
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          report("result strobe with no item outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_read_word !== want.read_word)
            report($sformatf("read_word %0d, expected %0d", out_read_word, want.read_word));
          if (out_element_count !== want.element_count)
            report($sformatf("element_count %0d, expected %0d",
                             out_element_count, want.element_count));
          if (out_status !== want.status)
            report($sformatf("status %0d, expected %s", out_status, want.status.name()));
        end
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (!(sent_count == total_items && results_seen >= total_items)) @(posedge clk);
    // Keep running a while to catch any stray strobe after the last result.
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      report($sformatf("%0d results never arrived", expected_results.size()));
    $display("Covered %0d items: ok %0d, full %0d, empty %0d, out of range %0d.",
             total_items, status_tally[ST_OK], status_tally[ST_FULL],
             status_tally[ST_EMPTY], status_tally[ST_RANGE]);
    $display("Deque filled to capacity %0d times; head pointer wrapped %0d times.",
             full_hits, head_wraps);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("timeout with %0d of %0d results seen", results_seen, total_items);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
